[sv/stp_port_role_selection_top_defines.svh]
// assertion macros for the spanning tree port role block
`ifndef STP_PORT_ROLE_SELECTION_TOP_DEFINES_SVH
`define STP_PORT_ROLE_SELECTION_TOP_DEFINES_SVH

// same-cycle implication
`define STP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stp check failed");

// next-cycle implication
`define STP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stp check failed");

`endif

[sv/stp_pkg.sv]
package stp_pkg;

    localparam int MAX_RESULTS = 24;

    typedef enum logic [2:0] {
        PS_DISABLED   = 3'd0,
        PS_LISTENING  = 3'd1,
        PS_LEARNING   = 3'd2,
        PS_FORWARDING = 3'd3,
        PS_BLOCKING   = 3'd4
    } t_pstate;

    typedef enum logic [1:0] {
        K_STATE  = 2'd0,
        K_CONFIG = 2'd1,
        K_TCN    = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        CFG_BRIDGE_ID  = 3'd0,
        CFG_STP_ENABLE = 3'd1,
        CFG_MAX_AGE    = 3'd2,
        CFG_HELLO      = 3'd3,
        CFG_FWD_DELAY  = 3'd4,
        CFG_PORT_PRIO  = 3'd5,
        CFG_PORT_MASK  = 3'd6,
        CFG_PATH_COST  = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_ROOT, S_ROOTSET, S_DSG, S_STATE,
        S_POST, S_CFG, S_TCN, S_SEND, S_FINISH
    } t_seq;

    typedef struct packed {
        logic        mode;
        logic [3:0]  rx_port;
        logic [63:0] msg_root_id;
        logic [31:0] msg_root_cost;
        logic [63:0] msg_bridge_id;
        logic [15:0] msg_port_id;
        logic [15:0] msg_max_age;
        logic [15:0] msg_hello;
        logic [15:0] msg_fwd_delay;
        logic        msg_tc;
        logic        msg_tc_ack;
    } t_bpdu_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  out_port;
        logic [2:0]  new_state;
        logic [63:0] tx_root_id;
        logic [31:0] tx_root_cost;
        logic [15:0] tx_port_id;
        logic        tx_tc;
        logic        tx_tc_ack;
        logic [15:0] tx_max_age;
        logic [15:0] tx_hello;
        logic [15:0] tx_fwd_delay;
        logic        last;
    } t_result;

    // priority vector, most significant field first
    typedef struct packed {
        logic [63:0] root;
        logic [31:0] cost;
        logic [63:0] bridge;
        logic [15:0] p1;
        logic [15:0] p2;
    } t_key;

    function automatic logic [15:0] f_pid(input logic [7:0] prio, input logic [7:0] num);
        return {prio, num};
    endfunction

endpackage

[sv/stp_cmp_unit.sv]
module stp_cmp_unit
    import stp_pkg::*;
(
    input  t_key i_a,
    input  t_key i_b,
    output logic o_lt,
    output logic o_eq
);
    // lexicographic compare of the whole priority vector
    assign o_lt = i_a < i_b;
    assign o_eq = i_a == i_b;
endmodule

[sv/stp_port_role_selection_top.sv]
// Spanning tree port role selection. Pulse start with a received BPDU or TCN
// word on i_item while busy is low; for a superseding BPDU the block records
// the info, then walks all ports for root selection, designated selection and
// state selection, and again for config transmission when it arrived on the
// root port. One shared priority-vector comparator serves the info check, root
// selection and designated selection. Config words go out on every designated
// port that is not disabled, and each port that falls back from learning or
// forwarding to blocking raises a topology change in a step of its own before
// its state word. A new item can be taken as soon as busy is low.
// Results appear on o_result for one cycle with o_valid high and cannot be
// stalled; the last word of an item has last set and comes out in the same
// cycle that busy drops. At most 24 result words per item, later ones are
// dropped. Configuration writes on i_cfg_we take effect at once and are only
// valid while idle.
`include "stp_port_role_selection_top_defines.svh"
module stp_port_role_selection_top
    import stp_pkg::*;
#(
    parameter int NUM_PORTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_bpdu_in    i_item,
    output logic        o_valid,
    output t_result     o_result,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);
    localparam int PW = $clog2(NUM_PORTS);
    localparam int IW = PW + 8;
    localparam int CW = $clog2(MAX_RESULTS + 1);
    localparam int RW = $bits(t_result);

    // configuration registers
    logic [63:0] r_bid;
    logic        r_stp_en;
    logic [7:0]  r_prio;
    logic [15:0] r_link;

    // per-port designated info
    t_pstate     r_pstate  [NUM_PORTS];
    logic [63:0] r_droot   [NUM_PORTS];
    logic [31:0] r_dcost   [NUM_PORTS];
    logic [63:0] r_dbr     [NUM_PORTS];
    logic [15:0] r_dport   [NUM_PORTS];
    logic        r_tca     [NUM_PORTS];

    // bridge info
    logic [PW:0] r_root_no;
    logic [63:0] r_bdroot;
    logic [31:0] r_bcost;
    logic [15:0] r_lt_ma, r_lt_hello, r_lt_fd;
    logic        r_tc, r_det;

    // sequencer
    t_seq        r_state, n_state;
    t_bpdu_in    r_in;
    logic        r_was_root;
    logic [PW-1:0] r_idx;
    logic [PW-1:0] r_rx_idx;
    logic        r_sub;
    logic [PW:0] r_best;
    t_key        r_bkey;
    logic [CW-1:0] r_cnt;
    t_result     r_pend;
    logic        r_pend_v;
    t_result     r_out;
    logic        r_out_v;

    // current port
    logic [PW-1:0] w_p;
    t_pstate     w_st;
    logic [63:0] w_droot, w_dbr;
    logic [31:0] w_dcost;
    logic [15:0] w_dport, w_pid;
    logic        w_tca;
    logic [IW-1:0] w_num, w_rp_wide, w_rx_wide;
    logic        w_desig, w_is_root, w_rp_valid, w_rx_ok, w_is_rp;
    logic [32:0] w_csum;
    logic [31:0] w_csat;
    t_key        w_ka, w_kb, w_cand;
    logic        w_lt, w_eq;
    logic        w_last_port;

    // control from the sequencer
    logic        w_emit, w_push;
    t_result     w_res;
    logic        w_store, w_take, w_become, w_set_st, w_clr_tca, w_set_tca;
    logic        w_do_tcd, w_post_rp, w_adv, w_sub_set, w_sub_clr;
    t_pstate     w_st_new;
    t_result     w_cfg_res, w_tcn_res;

    assign w_p     = (r_state == S_CHECK || r_state == S_TCN || r_state == S_SEND)
                     ? r_rx_idx : r_idx;
    assign w_st    = r_pstate[w_p];
    assign w_droot = r_droot[w_p];
    assign w_dcost = r_dcost[w_p];
    assign w_dbr   = r_dbr[w_p];
    assign w_dport = r_dport[w_p];
    assign w_tca   = r_tca[w_p];
    assign w_num   = IW'(w_p) + IW'(1);
    assign w_pid   = f_pid(r_prio, w_num[7:0]);
    assign w_desig = (w_dbr == r_bid) && (w_dport == w_pid);
    assign w_is_root  = r_bdroot == r_bid;
    assign w_rp_valid = r_root_no != '0;
    assign w_rp_wide  = IW'(r_root_no);
    assign w_rx_wide  = IW'(r_in.rx_port);
    assign w_rx_ok    = (r_in.rx_port != 4'd0) && (w_rx_wide <= IW'(NUM_PORTS));
    assign w_is_rp    = w_num == w_rp_wide;
    assign w_last_port = r_idx == PW'(NUM_PORTS - 1);

    // saturating root path cost through this port
    assign w_csum = {1'b0, w_dcost} + 33'(r_link);
    assign w_csat = w_csum[32] ? '1 : w_csum[31:0];
    assign w_cand = '{root: w_droot, cost: w_csat, bridge: w_dbr, p1: w_dport, p2: w_pid};

    // operand select for the shared comparator
    always_comb begin
        w_ka = w_cand;
        w_kb = r_bkey;
        unique case (r_state)
            S_CHECK: begin
                w_ka = '{root: r_in.msg_root_id, cost: r_in.msg_root_cost,
                         bridge: r_in.msg_bridge_id,
                         p1: (r_in.msg_bridge_id != r_bid) ? 16'd0 : r_in.msg_port_id,
                         p2: 16'd0};
                w_kb = '{root: w_droot, cost: w_dcost, bridge: w_dbr,
                         p1: (r_in.msg_bridge_id != r_bid) ? 16'd1 : w_dport,
                         p2: 16'd0};
            end
            S_DSG: begin
                w_ka = '{root: 64'd0, cost: r_bcost, bridge: r_bid, p1: w_pid, p2: 16'd0};
                w_kb = '{root: 64'd0, cost: w_dcost, bridge: w_dbr, p1: w_dport, p2: 16'd0};
            end
            default: ;
        endcase
    end

    stp_cmp_unit u_cmp (
        .i_a  (w_ka),
        .i_b  (w_kb),
        .o_lt (w_lt),
        .o_eq (w_eq)
    );

    always_comb begin
        w_cfg_res              = '0;
        w_cfg_res.kind         = K_CONFIG;
        w_cfg_res.out_port     = w_num[3:0];
        w_cfg_res.tx_root_id   = r_bdroot;
        w_cfg_res.tx_root_cost = r_bcost;
        w_cfg_res.tx_port_id   = w_pid;
        w_cfg_res.tx_tc        = r_tc;
        w_cfg_res.tx_tc_ack    = w_tca;
        w_cfg_res.tx_max_age   = r_lt_ma;
        w_cfg_res.tx_hello     = r_lt_hello;
        w_cfg_res.tx_fwd_delay = r_lt_fd;
        w_tcn_res              = '0;
        w_tcn_res.kind         = K_TCN;
        w_tcn_res.out_port     = w_rp_wide[3:0];
    end

    // sequencer: next state and per-step actions
    always_comb begin
        n_state   = r_state;
        w_emit    = 1'b0;
        w_res     = w_cfg_res;
        w_store   = 1'b0;
        w_take    = 1'b0;
        w_become  = 1'b0;
        w_set_st  = 1'b0;
        w_st_new  = PS_BLOCKING;
        w_clr_tca = 1'b0;
        w_set_tca = 1'b0;
        w_do_tcd  = 1'b0;
        w_post_rp = 1'b0;
        w_adv     = 1'b0;
        w_sub_set = 1'b0;
        w_sub_clr = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!w_rx_ok || w_st == PS_DISABLED) begin
                    n_state = S_FINISH;
                end else if (!r_in.mode) begin
                    if (w_lt || w_eq) begin
                        w_store = 1'b1;
                        n_state = S_ROOT;
                    end else if (w_desig) begin
                        n_state = S_SEND;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else if (w_desig) begin
                    n_state = S_TCN;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_ROOT: begin
                if (w_st != PS_DISABLED && !w_desig && (r_bid > w_droot)
                        && (r_best == '0 || w_lt))
                    w_take = 1'b1;
                w_adv = 1'b1;
                if (w_last_port) n_state = S_ROOTSET;
            end
            S_ROOTSET: n_state = S_DSG;
            S_DSG: begin
                if (w_st != PS_DISABLED && (w_desig || w_droot != r_bdroot || w_lt))
                    w_become = 1'b1;
                w_adv = 1'b1;
                if (w_last_port) n_state = S_STATE;
            end
            S_STATE: begin
                w_adv = 1'b1;
                if (w_st == PS_DISABLED) begin
                    w_adv = 1'b1;
                end else if (w_is_rp || w_desig) begin
                    w_clr_tca = w_is_rp;
                    if (w_st == PS_BLOCKING) begin
                        w_set_st = 1'b1;
                        w_st_new = r_stp_en ? PS_LISTENING : PS_LEARNING;
                    end
                end else begin
                    w_clr_tca = 1'b1;
                    if (w_st != PS_BLOCKING) begin
                        if ((w_st == PS_FORWARDING || w_st == PS_LEARNING) && !r_sub) begin
                            // topology change first, then the state word
                            w_do_tcd  = 1'b1;
                            w_sub_set = 1'b1;
                            w_adv     = 1'b0;
                        end else begin
                            w_set_st  = 1'b1;
                            w_st_new  = PS_BLOCKING;
                            w_sub_clr = 1'b1;
                        end
                    end
                end
                if (w_set_st) begin
                    w_emit              = 1'b1;
                    w_res               = '0;
                    w_res.kind          = K_STATE;
                    w_res.out_port      = w_num[3:0];
                    w_res.new_state     = w_st_new;
                end
                if (w_do_tcd) begin
                    w_emit = !w_is_root && !r_det && w_rp_valid;
                    w_res  = w_tcn_res;
                end
                if (w_adv && w_last_port) n_state = S_POST;
            end
            S_POST: begin
                if (!w_is_root && r_was_root && r_det && w_rp_valid) begin
                    w_emit = 1'b1;
                    w_res  = w_tcn_res;
                end
                if (w_rx_wide == w_rp_wide) begin
                    w_post_rp = 1'b1;
                    n_state   = S_CFG;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_CFG: begin
                if (w_st != PS_DISABLED && w_desig) begin
                    w_emit    = 1'b1;
                    w_clr_tca = 1'b1;
                end
                w_adv = 1'b1;
                if (w_last_port) n_state = S_FINISH;
            end
            S_TCN: begin
                w_do_tcd  = 1'b1;
                w_set_tca = 1'b1;
                w_emit    = !w_is_root && !r_det && w_rp_valid;
                w_res     = w_tcn_res;
                n_state   = S_SEND;
            end
            S_SEND: begin
                w_emit    = 1'b1;
                w_clr_tca = 1'b1;
                n_state   = S_FINISH;
            end
            S_FINISH: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // words beyond the per-item limit are dropped
    assign w_push = w_emit && (r_cnt < CW'(MAX_RESULTS));

    // walk counter, input capture and result words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_sub    <= 1'b0;
            r_best   <= '0;
            r_cnt    <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_out_v <= (w_push || r_state == S_FINISH) && r_pend_v;
            if (r_state == S_IDLE && start) begin
                r_in       <= i_item;
                r_rx_idx   <= PW'(i_item.rx_port - 4'd1);
                r_was_root <= w_is_root;
                r_idx      <= '0;
                r_best     <= '0;
                r_sub      <= 1'b0;
                r_cnt      <= '0;
            end
            if (w_adv) r_idx <= w_last_port ? '0 : r_idx + PW'(1);
            if (w_sub_set) r_sub <= 1'b1;
            if (w_sub_clr) r_sub <= 1'b0;
            if (w_take) begin
                r_best <= w_num[PW:0];
                r_bkey <= w_cand;
            end
            if (w_push) begin
                // previous word goes out, this one waits for a possible last flag
                if (r_pend_v) r_out <= {r_pend[RW-1:1], 1'b0};
                r_pend   <= w_res;
                r_pend_v <= 1'b1;
                r_cnt    <= r_cnt + CW'(1);
            end
            if (r_state == S_FINISH && r_pend_v) begin
                r_out    <= {r_pend[RW-1:1], 1'b1};
                r_pend_v <= 1'b0;
            end
        end
    end

    // protocol state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bid       <= '0;
            r_stp_en    <= 1'b1;
            r_prio      <= 8'd128;
            r_link      <= 16'd19;
            for (int k = 0; k < NUM_PORTS; k++) begin
                r_pstate[k] <= PS_BLOCKING;
                r_droot[k]  <= '0;
                r_dcost[k]  <= '0;
                r_dbr[k]    <= '0;
                r_dport[k]  <= f_pid(8'd128, 8'(k + 1));
                r_tca[k]    <= 1'b0;
            end
            r_root_no  <= '0;
            r_bdroot   <= '0;
            r_bcost    <= '0;
            r_lt_ma    <= 16'd20;
            r_lt_hello <= 16'd2;
            r_lt_fd    <= 16'd15;
            r_tc       <= 1'b0;
            r_det      <= 1'b0;
        end else begin
            if (w_store) begin
                r_droot[w_p] <= r_in.msg_root_id;
                r_dcost[w_p] <= r_in.msg_root_cost;
                r_dbr[w_p]   <= r_in.msg_bridge_id;
                r_dport[w_p] <= r_in.msg_port_id;
            end
            if (r_state == S_ROOTSET) begin
                r_root_no <= r_best;
                if (r_best == '0) begin
                    r_bdroot <= r_bid;
                    r_bcost  <= '0;
                end else begin
                    r_bdroot <= r_bkey.root;
                    r_bcost  <= r_bkey.cost;
                end
            end
            if (w_become) begin
                r_droot[w_p] <= r_bdroot;
                r_dcost[w_p] <= r_bcost;
                r_dbr[w_p]   <= r_bid;
                r_dport[w_p] <= w_pid;
            end
            if (w_set_st) r_pstate[w_p] <= w_st_new;
            if (w_clr_tca) r_tca[w_p] <= 1'b0;
            if (w_set_tca) r_tca[w_p] <= 1'b1;
            if (w_do_tcd) begin
                if (w_is_root) r_tc <= 1'b1;
                r_det <= 1'b1;
            end
            if (w_post_rp) begin
                r_lt_ma    <= r_in.msg_max_age;
                r_lt_hello <= r_in.msg_hello;
                r_lt_fd    <= r_in.msg_fwd_delay;
                r_tc       <= r_in.msg_tc;
                if (r_in.msg_tc_ack) r_det <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_BRIDGE_ID: begin
                        // stored copies of the old id follow the new one
                        r_bid <= i_cfg_data;
                        for (int k = 0; k < NUM_PORTS; k++) begin
                            if (r_dbr[k] == r_bid) r_dbr[k] <= i_cfg_data;
                            if (r_droot[k] == r_bid) r_droot[k] <= i_cfg_data;
                        end
                        if (w_is_root) r_bdroot <= i_cfg_data;
                    end
                    CFG_STP_ENABLE: r_stp_en <= i_cfg_data[0];
                    // own timers only matter while this bridge is root
                    CFG_MAX_AGE: begin
                        if (w_is_root) r_lt_ma <= i_cfg_data[15:0];
                    end
                    CFG_HELLO: begin
                        if (w_is_root) r_lt_hello <= i_cfg_data[15:0];
                    end
                    CFG_FWD_DELAY: begin
                        if (w_is_root) r_lt_fd <= i_cfg_data[15:0];
                    end
                    CFG_PORT_PRIO: begin
                        r_prio <= i_cfg_data[7:0];
                        for (int k = 0; k < NUM_PORTS; k++) begin
                            if (r_dbr[k] == r_bid && r_dport[k] == f_pid(r_prio, 8'(k + 1)))
                                r_dport[k] <= f_pid(i_cfg_data[7:0], 8'(k + 1));
                        end
                    end
                    // the enable mask lives on in the port states
                    CFG_PORT_MASK: begin
                        for (int k = 0; k < NUM_PORTS; k++) begin
                            if (k < 8) begin
                                if (!i_cfg_data[k] && r_pstate[k] != PS_DISABLED) begin
                                    r_pstate[k] <= PS_DISABLED;
                                    r_tca[k]    <= 1'b0;
                                end else if (i_cfg_data[k] && r_pstate[k] == PS_DISABLED) begin
                                    r_pstate[k] <= PS_BLOCKING;
                                    r_tca[k]    <= 1'b0;
                                    r_droot[k]  <= r_bdroot;
                                    r_dcost[k]  <= r_bcost;
                                    r_dbr[k]    <= r_bid;
                                    r_dport[k]  <= f_pid(r_prio, 8'(k + 1));
                                end
                            end
                        end
                    end
                    CFG_PATH_COST: r_link <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    assign busy     = r_state != S_IDLE;
    assign o_valid  = r_out_v;
    assign o_result = r_out;

    `STP_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(MAX_RESULTS))
    `STP_ASSERT_IMP(a_idle_no_pend, i_clk, i_rst_n, r_state == S_IDLE, !r_pend_v)
    `STP_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    `STP_ASSERT_NXT(a_finish_idle, i_clk, i_rst_n, r_state == S_FINISH, !busy)
    `STP_ASSERT_IMP(a_root_range, i_clk, i_rst_n, 1'b1, IW'(r_root_no) <= IW'(NUM_PORTS))
endmodule

[sim/stp_port_role_selection_top_test.sv]
`timescale 1ns / 100ps
module stp_port_role_selection_top_test;
    import stp_pkg::*;

    localparam int NPORTS = 8;
    localparam int TAIL_CYCLES = 5 * NPORTS + 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_bpdu_in    i_item = '0;
    logic        o_valid;
    t_result     o_result;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [63:0] i_cfg_data = '0;

    stp_port_role_selection_top #(.NUM_PORTS(NPORTS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_valid(o_valid), .o_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // half period of 1 ns gives a 2 ns clock
    always #1 i_clk = ~i_clk;

    // bridge model: configuration copy
    logic [63:0] br_id;
    logic        stp_on;
    logic [15:0] own_age, own_hello, own_fwd;
    logic [7:0]  prio, en_mask;
    logic [15:0] link_cost;

    // bridge model: per-port and bridge state
    t_pstate     pst [NPORTS];
    logic [63:0] d_root [NPORTS];
    logic [31:0] d_cost [NPORTS];
    logic [63:0] d_bridge [NPORTS];
    logic [15:0] d_port [NPORTS];
    logic        ack_pend [NPORTS];
    int          root_no;
    logic [63:0] b_root;
    logic [31:0] b_cost;
    logic [15:0] lt_age, lt_hello, lt_fwd;
    logic        tc_flag, tc_det;

    t_result     pending_words [$];   // words the block owes us
    t_bpdu_in    bpdu_queue [$];      // items waiting for the driver
    int          word_cnt;            // words of the current item
    int          fail_cnt = 0;
    int          word_total = 0;
    int          item_total = 0;
    bit          hold_sender = 1'b0;

    function automatic logic [15:0] port_id(int i);
        return {prio, 8'(i + 1)};
    endfunction

    function automatic logic [31:0] cost_sum(logic [31:0] a, logic [15:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {17'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic bit is_dsg(int i);
        return d_bridge[i] == br_id && d_port[i] == port_id(i);
    endfunction

    function automatic bit we_are_root();
        return b_root == br_id;
    endfunction

    function automatic void push_word(t_result w);
        if (word_cnt < MAX_RESULTS) begin
            pending_words.push_back(w);
            word_cnt++;
        end
    endfunction

    function automatic void emit_config(int i);
        t_result w;
        w = '0;
        w.kind = K_CONFIG;
        w.out_port = 4'(i + 1);
        w.tx_root_id = b_root;
        w.tx_root_cost = b_cost;
        w.tx_port_id = port_id(i);
        w.tx_tc = tc_flag;
        w.tx_tc_ack = ack_pend[i];
        w.tx_max_age = lt_age;
        w.tx_hello = lt_hello;
        w.tx_fwd_delay = lt_fwd;
        push_word(w);
        ack_pend[i] = 1'b0;
    endfunction

    function automatic void emit_tcn();
        t_result w;
        if (root_no >= 1 && root_no <= NPORTS) begin
            w = '0;
            w.kind = K_TCN;
            w.out_port = 4'(root_no);
            push_word(w);
        end
    endfunction

    function automatic void move_state(int i, t_pstate s);
        t_result w;
        pst[i] = s;
        w = '0;
        w.kind = K_STATE;
        w.out_port = 4'(i + 1);
        w.new_state = s;
        push_word(w);
    endfunction

    function automatic void note_topo_change();
        if (we_are_root()) tc_flag = 1'b1;
        else if (!tc_det) emit_tcn();
        tc_det = 1'b1;
    endfunction

    function automatic bit port_beats(int i, int r);
        logic [31:0] ci, cr;
        if (d_root[i] != d_root[r]) return d_root[i] < d_root[r];
        ci = cost_sum(d_cost[i], link_cost);
        cr = cost_sum(d_cost[r], link_cost);
        if (ci != cr) return ci < cr;
        if (d_bridge[i] != d_bridge[r]) return d_bridge[i] < d_bridge[r];
        if (d_port[i] != d_port[r]) return d_port[i] < d_port[r];
        return port_id(i) < port_id(r);
    endfunction

    function automatic void take_designated(int i);
        d_root[i] = b_root;
        d_cost[i] = b_cost;
        d_bridge[i] = br_id;
        d_port[i] = port_id(i);
    endfunction

    function automatic void reselect_roles();
        int best;
        bit want;
        best = 0;
        for (int i = 0; i < NPORTS; i++) begin
            if (pst[i] == PS_DISABLED || is_dsg(i)) continue;
            if (br_id <= d_root[i]) continue;
            if (best == 0 || port_beats(i, best - 1)) best = i + 1;
        end
        root_no = best;
        if (best == 0) begin
            b_root = br_id;
            b_cost = '0;
        end else begin
            b_root = d_root[best - 1];
            b_cost = cost_sum(d_cost[best - 1], link_cost);
        end
        // designated selection
        for (int i = 0; i < NPORTS; i++) begin
            if (pst[i] == PS_DISABLED) continue;
            if (is_dsg(i) || d_root[i] != b_root) want = 1'b1;
            else if (b_cost != d_cost[i]) want = b_cost < d_cost[i];
            else if (br_id != d_bridge[i]) want = br_id < d_bridge[i];
            else want = port_id(i) < d_port[i];
            if (want) take_designated(i);
        end
        // state selection
        for (int i = 0; i < NPORTS; i++) begin
            if (pst[i] == PS_DISABLED) continue;
            if (i + 1 == root_no || is_dsg(i)) begin
                if (i + 1 == root_no) ack_pend[i] = 1'b0;
                if (pst[i] == PS_BLOCKING)
                    move_state(i, stp_on ? PS_LISTENING : PS_LEARNING);
            end else begin
                ack_pend[i] = 1'b0;
                if (pst[i] != PS_BLOCKING) begin
                    if (pst[i] == PS_FORWARDING || pst[i] == PS_LEARNING)
                        note_topo_change();
                    move_state(i, PS_BLOCKING);
                end
            end
        end
    endfunction

    function automatic bit info_supersedes(int i, t_bpdu_in b);
        if (b.msg_root_id != d_root[i]) return b.msg_root_id < d_root[i];
        if (b.msg_root_cost != d_cost[i]) return b.msg_root_cost < d_cost[i];
        if (b.msg_bridge_id != d_bridge[i]) return b.msg_bridge_id < d_bridge[i];
        if (b.msg_bridge_id != br_id) return 1'b1;
        return b.msg_port_id <= d_port[i];
    endfunction

    function automatic void model_reset();
        br_id = '0; stp_on = 1'b1;
        own_age = 16'd20; own_hello = 16'd2; own_fwd = 16'd15;
        prio = 8'd128; en_mask = 8'hFF; link_cost = 16'd19;
        for (int i = 0; i < NPORTS; i++) begin
            pst[i] = PS_BLOCKING;
            d_root[i] = br_id; d_cost[i] = '0; d_bridge[i] = br_id;
            d_port[i] = port_id(i); ack_pend[i] = 1'b0;
        end
        root_no = 0; b_root = br_id; b_cost = '0;
        lt_age = own_age; lt_hello = own_hello; lt_fwd = own_fwd;
        tc_flag = 1'b0; tc_det = 1'b0;
    endfunction

    function automatic void model_write(t_cfg_idx idx, logic [63:0] v);
        bit root_before;
        bit dsg_before [NPORTS];
        case (idx)
            CFG_BRIDGE_ID: begin
                root_before = we_are_root();
                for (int i = 0; i < NPORTS; i++) begin
                    if (d_bridge[i] == br_id) d_bridge[i] = v;
                    if (d_root[i] == br_id) d_root[i] = v;
                end
                br_id = v;
                if (root_before) b_root = v;
            end
            CFG_STP_ENABLE: stp_on = v[0];
            CFG_MAX_AGE: begin
                own_age = v[15:0];
                if (we_are_root()) lt_age = own_age;
            end
            CFG_HELLO: begin
                own_hello = v[15:0];
                if (we_are_root()) lt_hello = own_hello;
            end
            CFG_FWD_DELAY: begin
                own_fwd = v[15:0];
                if (we_are_root()) lt_fwd = own_fwd;
            end
            CFG_PORT_PRIO: begin
                for (int i = 0; i < NPORTS; i++) dsg_before[i] = is_dsg(i);
                prio = v[7:0];
                for (int i = 0; i < NPORTS; i++)
                    if (dsg_before[i]) d_port[i] = port_id(i);
            end
            CFG_PORT_MASK: begin
                en_mask = v[7:0];
                for (int i = 0; i < NPORTS && i < 8; i++) begin
                    if (!en_mask[i] && pst[i] != PS_DISABLED) begin
                        pst[i] = PS_DISABLED;
                        ack_pend[i] = 1'b0;
                    end else if (en_mask[i] && pst[i] == PS_DISABLED) begin
                        pst[i] = PS_BLOCKING;
                        ack_pend[i] = 1'b0;
                        take_designated(i);
                    end
                end
            end
            CFG_PATH_COST: link_cost = v[15:0];
            default: ;
        endcase
    endfunction

    // expected words for one accepted item
    function automatic void predict_bpdu(t_bpdu_in b);
        int i;
        bit root_before;
        word_cnt = 0;
        if (b.rx_port < 1 || b.rx_port > NPORTS) return;
        i = b.rx_port - 1;
        if (pst[i] == PS_DISABLED) return;
        if (!b.mode) begin
            root_before = we_are_root();
            if (info_supersedes(i, b)) begin
                d_root[i] = b.msg_root_id;
                d_cost[i] = b.msg_root_cost;
                d_bridge[i] = b.msg_bridge_id;
                d_port[i] = b.msg_port_id;
                reselect_roles();
                if (!we_are_root() && root_before && tc_det) emit_tcn();
                if (b.rx_port == root_no) begin
                    lt_age = b.msg_max_age;
                    lt_hello = b.msg_hello;
                    lt_fwd = b.msg_fwd_delay;
                    tc_flag = b.msg_tc;
                    for (int k = 0; k < NPORTS; k++)
                        if (pst[k] != PS_DISABLED && is_dsg(k)) emit_config(k);
                    if (b.msg_tc_ack) tc_det = 1'b0;
                end
            end else if (is_dsg(i)) begin
                emit_config(i);
            end
        end else if (is_dsg(i)) begin
            note_topo_change();
            ack_pend[i] = 1'b1;
            emit_config(i);
        end
        if (word_cnt > 0) pending_words[pending_words.size() - 1].last = 1'b1;
    endfunction

    // mostly short gaps, sometimes long, sometimes none
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // driver: feeds items from the queue, start held until accepted
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy) begin
            predict_bpdu(i_item);
            item_total++;
            send_gap = gap_len();
            if (send_gap == 0 && bpdu_queue.size() > 0 && !hold_sender) begin
                i_item <= bpdu_queue.pop_front();
            end else begin
                start <= 1'b0;
            end
        end else if (!start) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (bpdu_queue.size() > 0 && !hold_sender) begin
                i_item <= bpdu_queue.pop_front();
                start <= 1'b1;
            end
        end
    end

    // monitor: every strobed word against the oldest expectation
    t_result exp_word;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            word_total++;
            if (pending_words.size() == 0) begin
                $error("unexpected word kind=%0d port=%0d", o_result.kind,
                       o_result.out_port);
                fail_cnt++;
            end else begin
                exp_word = pending_words.pop_front();
                if (o_result !== exp_word) begin
                    fail_cnt++;
                    if (o_result.kind !== exp_word.kind)
                        $error("kind exp %0d got %0d", exp_word.kind, o_result.kind);
                    if (o_result.out_port !== exp_word.out_port)
                        $error("out_port exp %0d got %0d", exp_word.out_port,
                               o_result.out_port);
                    if (o_result.new_state !== exp_word.new_state)
                        $error("new_state exp %0d got %0d", exp_word.new_state,
                               o_result.new_state);
                    if (o_result.tx_root_id !== exp_word.tx_root_id)
                        $error("tx_root_id exp %h got %h", exp_word.tx_root_id,
                               o_result.tx_root_id);
                    if (o_result.tx_root_cost !== exp_word.tx_root_cost)
                        $error("tx_root_cost exp %h got %h", exp_word.tx_root_cost,
                               o_result.tx_root_cost);
                    if (o_result.tx_port_id !== exp_word.tx_port_id)
                        $error("tx_port_id exp %h got %h", exp_word.tx_port_id,
                               o_result.tx_port_id);
                    if (o_result.tx_tc !== exp_word.tx_tc)
                        $error("tx_tc exp %0d got %0d", exp_word.tx_tc, o_result.tx_tc);
                    if (o_result.tx_tc_ack !== exp_word.tx_tc_ack)
                        $error("tx_tc_ack exp %0d got %0d", exp_word.tx_tc_ack,
                               o_result.tx_tc_ack);
                    if (o_result.tx_max_age !== exp_word.tx_max_age)
                        $error("tx_max_age exp %h got %h", exp_word.tx_max_age,
                               o_result.tx_max_age);
                    if (o_result.tx_hello !== exp_word.tx_hello)
                        $error("tx_hello exp %h got %h", exp_word.tx_hello,
                               o_result.tx_hello);
                    if (o_result.tx_fwd_delay !== exp_word.tx_fwd_delay)
                        $error("tx_fwd_delay exp %h got %h", exp_word.tx_fwd_delay,
                               o_result.tx_fwd_delay);
                    if (o_result.last !== exp_word.last)
                        $error("last exp %0d got %0d", exp_word.last, o_result.last);
                end
            end
        end
    end

    // random identifier drawn near a small pool so comparisons tie often
    logic [63:0] id_pool [4];
    function automatic logic [63:0] pick_id();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return id_pool[$urandom_range(0, 3)] + 64'($urandom_range(0, 2));
        if (r == 7) return 64'hFFFF_FFFF_FFFF_FFFF;
        if (r == 8) return '0;
        return {$urandom, $urandom};
    endfunction

    function automatic t_bpdu_in rand_bpdu();
        t_bpdu_in b;
        int r;
        b.mode = ($urandom_range(0, 4) == 0);
        r = $urandom_range(0, 29);
        b.rx_port = (r == 0) ? 4'($urandom_range(9, 15)) :
                    (r == 1) ? 4'd0 : 4'($urandom_range(1, NPORTS));
        b.msg_root_id = pick_id();
        r = $urandom_range(0, 9);
        b.msg_root_cost = (r < 6) ? 32'($urandom_range(0, 200)) :
                          (r < 8) ? 32'hFFFF_FFFF - 32'($urandom_range(0, 40)) : $urandom;
        b.msg_bridge_id = pick_id();
        b.msg_port_id = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                        {prio, 8'($urandom_range(1, NPORTS))};
        b.msg_max_age = 16'($urandom);
        b.msg_hello = 16'($urandom);
        b.msg_fwd_delay = 16'($urandom);
        b.msg_tc = 1'($urandom);
        b.msg_tc_ack = 1'($urandom);
        return b;
    endfunction

    task automatic wait_drained();
        while (bpdu_queue.size() > 0 || start || busy || pending_words.size() > 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [63:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        model_write(idx, v);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_bpdu_in b;
        model_reset();
        id_pool[0] = 64'h8000_0011_2233_4455;
        id_pool[1] = 64'h1000_0000_0000_0100;
        id_pool[2] = 64'h8000_0000_0000_0010;
        id_pool[3] = 64'hF000_AAAA_BBBB_CCCC;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: own id mid-range so better and worse roots exist
        write_reg(CFG_BRIDGE_ID, id_pool[2]);
        for (int n = 0; n < 22; n++) begin
            b = rand_bpdu();
            case (n)
                0: begin b.mode = 1'b0; b.rx_port = 4'd1; b.msg_root_id = '0;
                          b.msg_root_cost = '0; end
                1: begin b.mode = 1'b0; b.rx_port = 4'd2; b.msg_root_id = '0;
                          b.msg_root_cost = 32'hFFFF_FFFF; end
                2: begin b.mode = 1'b1; b.rx_port = 4'd3; end
                3: b.rx_port = 4'd0;
                4: b.rx_port = 4'd15;
                5: begin b.mode = 1'b0; b.rx_port = 4'd8;
                          b.msg_root_id = 64'hFFFF_FFFF_FFFF_FFFF; end
                6: begin b.mode = 1'b1; b.rx_port = 4'd1; end
                7: begin b.mode = 1'b0; b.rx_port = 4'd1; b.msg_root_id = '0;
                          b.msg_root_cost = '0; b.msg_bridge_id = '0;
                          b.msg_tc_ack = 1'b1; end
                default: ;
            endcase
            bpdu_queue.push_back(b);
        end
        wait_drained();

        // disabled ports, tcn without root port, register extremes
        write_reg(CFG_PORT_MASK, 64'h00);
        write_reg(CFG_PORT_MASK, 64'h5A);
        b = rand_bpdu(); b.rx_port = 4'd1; bpdu_queue.push_back(b);
        b = rand_bpdu(); b.mode = 1'b1; b.rx_port = 4'd2; bpdu_queue.push_back(b);
        wait_drained();
        write_reg(CFG_PORT_MASK, 64'hFF);
        write_reg(CFG_STP_ENABLE, 64'd0);
        write_reg(CFG_PATH_COST, 64'hFFFF);
        write_reg(CFG_PORT_PRIO, 64'h00);

        // random phases, each starting from another setting
        for (int ph = 0; ph < 6; ph++) begin
            for (int n = 0; n < 60; n++) bpdu_queue.push_back(rand_bpdu());
            if (ph == 2) begin
                // sender waits for the block to drain once mid-phase
                while (bpdu_queue.size() > 30) @(posedge i_clk);
                hold_sender = 1'b1;
                while (start || busy || pending_words.size() > 0) @(posedge i_clk);
                hold_sender = 1'b0;
            end
            wait_drained();
            case (ph)
                0: begin write_reg(CFG_BRIDGE_ID, 64'hFFFF_FFFF_FFFF_FFFF);
                         write_reg(CFG_MAX_AGE, 64'hFFFF); write_reg(CFG_HELLO, 64'd0);
                         write_reg(CFG_FWD_DELAY, 64'hFFFF); end
                1: begin write_reg(CFG_PORT_PRIO, 64'hFF); write_reg(CFG_PATH_COST, 64'd1);
                         write_reg(CFG_STP_ENABLE, 64'd1); end
                2: begin write_reg(CFG_BRIDGE_ID, 64'd0); write_reg(CFG_MAX_AGE, 64'd0);
                         write_reg(CFG_HELLO, 64'hFFFF); write_reg(CFG_FWD_DELAY, 64'd0); end
                3: begin write_reg(CFG_BRIDGE_ID, id_pool[0]);
                         write_reg(CFG_PORT_MASK, 64'($urandom_range(0, 255)));
                         write_reg(CFG_PORT_PRIO, 64'd128); end
                4: begin write_reg(CFG_PORT_MASK, 64'hFF);
                         write_reg(CFG_PATH_COST, 64'($urandom_range(1, 65535))); end
                default: ;
            endcase
        end

        $display("covered %0d accepted items and %0d result words", item_total, word_total);
        $display("register phases swept bridge id, timers, priority, mask and cost extremes");
        if (fail_cnt == 0)
            $display("stp_port_role_selection_top_test passed");
        else
            $display("stp_port_role_selection_top_test failed");
        $finish;
    end

    // watchdog
    initial begin
        #4000000;
        $display("stp_port_role_selection_top_test failed");
        $finish;
    end

endmodule
